### sv/egsa_pkg.sv
// Shared types and codes for the embedding gradient scatter-add table.
// Used by embedding_grad_scatter_add; depends on nothing else.
package egsa_pkg;

    localparam int MAX_ROWS_DEF  = 1024;
    localparam int MAX_WIDTH_DEF = 64;

    localparam int OP_W     = 2;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    localparam int ROWCNT_W = 11;
    localparam int VECW_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ROW_BAD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COL_BAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_WIDTH = 1'd1;

    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST    = 11'd1024;
    localparam logic [VECW_W-1:0]   VECTOR_WIDTH_RST = 7'd64;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [ROW_W-1:0]        row_index;
        logic [COL_W-1:0]        column_index;
        logic signed [VAL_W-1:0] grad_value;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] entry_value;
        logic [STATUS_W-1:0]     status;
        logic                    saturated;
    } t_result;

endpackage

### sv/embedding_grad_scatter_add.sv
// Embedding gradient table: saturating Q16.16 scatter-add into a single-port RAM.
// Depends on egsa_pkg for the item/result structs, op codes and status codes.
//
//   channel   ports                           handshake
//   --------  ------------------------------  -------------------------------
//   item in   i_item                          transfer when start && !busy
//   result    o_result                        o_valid, one cycle, no stall
//   config    i_cfg_index, i_cfg_data         write when i_cfg_we
//
// Accumulate, read and unused op codes pass through S_EXEC: the RAM is read at accept
// for an in-range access, then S_EXEC does add/saturate and write-back; busy is high
// in S_EXEC. A clear sweeps the RAM one entry per cycle, then gives the result. After
// reset the same sweep runs with busy high and no result. Results are registered and
// show in the cycle after S_EXEC or the last sweep write; the receiver cannot stall.
module embedding_grad_scatter_add #(
    parameter int MAX_ROWS  = egsa_pkg::MAX_ROWS_DEF,
    parameter int MAX_WIDTH = egsa_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  egsa_pkg::t_item                     i_item,
    output logic                                o_valid,
    output egsa_pkg::t_result                   o_result,
    input  logic                                i_cfg_we,
    input  logic [egsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [egsa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VAL_W  = egsa_pkg::VAL_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [1:0]                      r_state;
    logic [egsa_pkg::ROWCNT_W-1:0]   r_row_count;
    logic [egsa_pkg::VECW_W-1:0]     r_vector_width;
    logic [egsa_pkg::OP_W-1:0]       r_op;
    logic [egsa_pkg::STATUS_W-1:0]   r_status;
    logic [VAL_W-1:0]                r_grad;
    logic [ADDR_W-1:0]               r_addr;
    logic [ADDR_W-1:0]               r_clr_addr;
    logic                            r_clr_report;
    logic                            r_out_valid;
    egsa_pkg::t_result               r_out;
    logic [VAL_W-1:0]                r_rd_data;
    logic [VAL_W-1:0]                r_mem [DEPTH];

    logic                            accept;
    logic [egsa_pkg::STATUS_W-1:0]   n_status;
    logic [31:0]                     addr_full;
    logic [ADDR_W-1:0]               n_addr;
    logic                            rd_en;
    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [VAL_W-1:0]                wr_data;
    logic [VAL_W:0]                  sum;
    logic [VAL_W-1:0]                sum_sat;
    logic                            sum_ovf;
    egsa_pkg::t_result               n_out;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Range check on the incoming item; row is checked before column.
    always_comb begin
        n_status = egsa_pkg::ST_OK;
        if (i_item.operation inside {egsa_pkg::OP_ACCUM, egsa_pkg::OP_READ}) begin
            if (({1'b0, i_item.row_index} >= r_row_count) ||
                (32'(i_item.row_index) >= MAX_ROWS)) begin
                n_status = egsa_pkg::ST_ROW_BAD;
            end else if (({1'b0, i_item.column_index} >= r_vector_width) ||
                         (32'(i_item.column_index) >= MAX_WIDTH)) begin
                n_status = egsa_pkg::ST_COL_BAD;
            end
        end
    end

    assign addr_full = 32'(i_item.row_index) * 32'(MAX_WIDTH) + 32'(i_item.column_index);
    assign n_addr    = addr_full[ADDR_W-1:0];
    assign rd_en     = accept && (n_status == egsa_pkg::ST_OK) &&
                       (i_item.operation inside {egsa_pkg::OP_ACCUM, egsa_pkg::OP_READ});

    // Add and clamp to the signed 32-bit range.
    assign sum     = {r_rd_data[VAL_W-1], r_rd_data} + {r_grad[VAL_W-1], r_grad};
    assign sum_ovf = (sum[VAL_W] != sum[VAL_W-1]);
    assign sum_sat = !sum_ovf ? sum[VAL_W-1:0] :
                     (sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});

    always_comb begin
        n_out   = '0;
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = sum_sat;
        if (r_state == S_EXEC) begin
            n_out.status = r_status;
            if (r_status == egsa_pkg::ST_OK) begin
                case (r_op)
                    egsa_pkg::OP_ACCUM: begin
                        wr_en             = 1'b1;
                        n_out.entry_value = sum_sat;
                        n_out.saturated   = sum_ovf;
                    end
                    egsa_pkg::OP_READ: begin
                        n_out.entry_value = r_rd_data;
                    end
                    default: begin
                        n_out = '0;
                    end
                endcase
            end
        end else if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_clr_report   <= 1'b0;
            r_out_valid    <= 1'b0;
            r_row_count    <= egsa_pkg::ROW_COUNT_RST;
            r_vector_width <= egsa_pkg::VECTOR_WIDTH_RST;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    egsa_pkg::CFG_ROW_COUNT:    r_row_count <= i_cfg_data;
                    egsa_pkg::CFG_VECTOR_WIDTH:
                        r_vector_width <= i_cfg_data[egsa_pkg::VECW_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.operation == egsa_pkg::OP_CLEAR) begin
                            r_state      <= S_CLEAR;
                            r_clr_addr   <= '0;
                            r_clr_report <= 1'b1;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_CLEAR: begin
                    // advance the sweep; report only for a requested clear
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= r_clr_report;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_item.operation;
            r_status <= n_status;
            r_grad   <= i_item.grad_value;
            r_addr   <= n_addr;
        end
        if (r_state == S_EXEC) begin
            r_out <= n_out;
        end else if (r_state == S_CLEAR) begin
            r_out <= '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held two cycles");

    a_access_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.operation != egsa_pkg::OP_CLEAR) |=> ##1 o_valid)
        else $error("access result missing two cycles after transfer");

    a_bad_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != egsa_pkg::ST_OK) |->
        (o_result.entry_value == '0 && !o_result.saturated))
        else $error("out-of-range access returned data");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
        (o_result.entry_value == 32'sh7FFFFFFF || o_result.entry_value == 32'sh80000000))
        else $error("saturated flag without clamped value");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for embedding_grad_scatter_add, the Q16.16 gradient table.
// Depends on egsa_pkg for the item/result structs, op, status and register codes.
// Directed rows first, then random phases across several table-size settings.
module tb_top;

    localparam logic [egsa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT     = 270000;
    localparam int HOT_ENTRIES     = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int REPORT_LIMIT    = 10;
    localparam int ITEM_W          = $bits(egsa_pkg::t_item);

    typedef struct packed {
        logic                            is_cfg;
        logic [egsa_pkg::CFG_IDX_W-1:0]  cfg_index;
        logic [egsa_pkg::CFG_DATA_W-1:0] cfg_data;
        egsa_pkg::t_item                 item;
        logic                            fixed;
        egsa_pkg::t_result               want;
    } t_directed_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    egsa_pkg::t_item                 i_item;
    logic                            o_valid;
    egsa_pkg::t_result               o_result;
    logic                            i_cfg_we;
    logic [egsa_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [egsa_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // shadow copy of the table and registers; missing keys read as zero
    logic signed [egsa_pkg::VAL_W-1:0] shadow_table [int];
    logic [egsa_pkg::ROWCNT_W-1:0]     row_count_q = egsa_pkg::ROW_COUNT_RST;
    logic [egsa_pkg::VECW_W-1:0]       vector_width_q = egsa_pkg::VECTOR_WIDTH_RST;

    egsa_pkg::t_result pending_sums [$];
    t_directed_row     dir_rows [$];
    int                bad_results = 0;
    int                quiet_cycles = 0;
    int                burst_left = 0;

    embedding_grad_scatter_add uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic egsa_pkg::t_result scatter_add_predict(egsa_pkg::t_item it);
        egsa_pkg::t_result r;
        int      rows_eff;
        int      cols_eff;
        int      addr;
        longint  cur;
        longint  sum;
        r = '0;
        rows_eff = (row_count_q > egsa_pkg::MAX_ROWS_DEF) ?
                   egsa_pkg::MAX_ROWS_DEF : int'(row_count_q);
        cols_eff = (vector_width_q > egsa_pkg::MAX_WIDTH_DEF) ?
                   egsa_pkg::MAX_WIDTH_DEF : int'(vector_width_q);
        if (it.operation == egsa_pkg::OP_CLEAR) begin
            shadow_table.delete();
        end else if (it.operation == egsa_pkg::OP_ACCUM ||
                     it.operation == egsa_pkg::OP_READ) begin
            if (int'(it.row_index) >= rows_eff) begin
                r.status = egsa_pkg::ST_ROW_BAD;
            end else if (int'(it.column_index) >= cols_eff) begin
                r.status = egsa_pkg::ST_COL_BAD;
            end else begin
                addr = int'(it.row_index) * egsa_pkg::MAX_WIDTH_DEF + int'(it.column_index);
                cur = shadow_table.exists(addr) ? longint'(shadow_table[addr]) : 0;
                if (it.operation == egsa_pkg::OP_ACCUM) begin
                    sum = cur + longint'($signed(it.grad_value));
                    if (sum > 64'sd2147483647) begin
                        sum = 64'sd2147483647;
                        r.saturated = 1'b1;
                    end else if (sum < -64'sd2147483648) begin
                        sum = -64'sd2147483648;
                        r.saturated = 1'b1;
                    end
                    shadow_table[addr] = sum[egsa_pkg::VAL_W-1:0];
                    cur = sum;
                end
                r.entry_value = cur[egsa_pkg::VAL_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic t_directed_row op_row(logic [egsa_pkg::OP_W-1:0] op,
                                             logic [egsa_pkg::ROW_W-1:0] row,
                                             logic [egsa_pkg::COL_W-1:0] col,
                                             logic [egsa_pkg::VAL_W-1:0] grad,
                                             logic fixed,
                                             logic [egsa_pkg::VAL_W-1:0] val,
                                             logic [egsa_pkg::STATUS_W-1:0] st,
                                             logic sat);
        t_directed_row d;
        d = '0;
        d.item.operation    = op;
        d.item.row_index    = row;
        d.item.column_index = col;
        d.item.grad_value   = grad;
        d.fixed             = fixed;
        d.want.entry_value  = val;
        d.want.status       = st;
        d.want.saturated    = sat;
        return d;
    endfunction

    function automatic t_directed_row reg_row(logic [egsa_pkg::CFG_IDX_W-1:0] idx,
                                              logic [egsa_pkg::CFG_DATA_W-1:0] data);
        t_directed_row d;
        d = '0;
        d.is_cfg    = 1'b1;
        d.cfg_index = idx;
        d.cfg_data  = data;
        return d;
    endfunction

    function automatic void add_row(t_directed_row d);
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic drive_item(input egsa_pkg::t_item it, input logic fixed,
                              input egsa_pkg::t_result want);
        egsa_pkg::t_result sum_exp;
        int      gap;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sum_exp = scatter_add_predict(it);
        pending_sums.insert(pending_sums.size(), fixed ? want : sum_exp);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Hold off until every result is back and the block is idle, then write.
    task automatic write_reg(input logic [egsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [egsa_pkg::CFG_DATA_W-1:0] data);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0 || busy) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == egsa_pkg::CFG_ROW_COUNT) begin
            row_count_q = data[egsa_pkg::ROWCNT_W-1:0];
        end else begin
            vector_width_q = data[egsa_pkg::VECW_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        egsa_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_sums.size() == 0) begin
                if (bad_results < REPORT_LIMIT)
                    $display("unexpected result at %0t: value %h status %0d sat %0d",
                             $time, o_result.entry_value, o_result.status,
                             o_result.saturated);
                bad_results++;
            end else begin
                want = pending_sums.pop_front();
                if (o_result.entry_value !== want.entry_value ||
                    o_result.status !== want.status ||
                    o_result.saturated !== want.saturated) begin
                    if (bad_results < REPORT_LIMIT)
                        $display({"mismatch at %0t: want value %h status %0d sat %0d,",
                                  " got value %h status %0d sat %0d"},
                                 $time, want.entry_value, want.status, want.saturated,
                                 o_result.entry_value, o_result.status,
                                 o_result.saturated);
                    bad_results++;
                end
            end
        end
    end

    // End the run when neither an item nor a result moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        egsa_pkg::t_item  it;
        int               ph;
        int               k;
        int               pick;
        int               hidx;
        int               lim_rows;
        int               lim_cols;
        int               clears_left;
        logic [egsa_pkg::CFG_DATA_W-1:0] rows_cfg;
        logic [egsa_pkg::CFG_DATA_W-1:0] cols_cfg;
        logic [egsa_pkg::ROW_W-1:0]      hot_row [HOT_ENTRIES];
        logic [egsa_pkg::COL_W-1:0]      hot_col [HOT_ENTRIES];

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        clears_left = 3;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: 1024 rows, 64 columns
        add_row(op_row(egsa_pkg::OP_READ,  10'd0,    6'd0,  32'h0,        1, 32'h0,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd0,    6'd0,  32'h7FFFFFFF, 1, 32'h7FFFFFFF,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd0,    6'd0,  32'h1,        1, 32'h7FFFFFFF,
                       egsa_pkg::ST_OK, 1));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd1023, 6'd63, 32'h80000000, 1, 32'h80000000,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd1023, 6'd63, 32'hFFFFFFFF, 1, 32'h80000000,
                       egsa_pkg::ST_OK, 1));
        add_row(op_row(egsa_pkg::OP_READ,  10'd1023, 6'd63, 32'hFFFFFFFF, 1, 32'h80000000,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd0,    6'd0,  32'h80000000, 1, 32'hFFFFFFFF,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(OP_UNUSED,          10'd1023, 6'd63, 32'hFFFFFFFF, 1, 32'h0,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd5,    6'd7,  32'h00018000, 0, 0,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd5,    6'd7,  32'hFFFF4000, 0, 0,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_READ,  10'd5,    6'd7,  32'h0,        0, 0,
                       egsa_pkg::ST_OK, 0));
        // clear ignores its other fields
        add_row(op_row(egsa_pkg::OP_CLEAR, 10'd1023, 6'd63, 32'hFFFFFFFF, 1, 32'h0,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_READ,  10'd0,    6'd0,  32'h0,        1, 32'h0,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_READ,  10'd1023, 6'd63, 32'h0,        1, 32'h0,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_READ,  10'd5,    6'd7,  32'h0,        1, 32'h0,
                       egsa_pkg::ST_OK, 0));
        // shrink to 4 rows by 2 columns; row is checked before column
        add_row(reg_row(egsa_pkg::CFG_ROW_COUNT, 11'd4));
        add_row(reg_row(egsa_pkg::CFG_VECTOR_WIDTH, 11'd2));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd4,    6'd0,  32'h1,        1, 32'h0,
                       egsa_pkg::ST_ROW_BAD, 0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd1023, 6'd63, 32'h7FFFFFFF, 1, 32'h0,
                       egsa_pkg::ST_ROW_BAD, 0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd3,    6'd2,  32'h1,        1, 32'h0,
                       egsa_pkg::ST_COL_BAD, 0));
        add_row(op_row(egsa_pkg::OP_READ,  10'd0,    6'd63, 32'h0,        1, 32'h0,
                       egsa_pkg::ST_COL_BAD, 0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd3,    6'd1,  32'h12345678, 0, 0,
                       egsa_pkg::ST_OK, 0));
        add_row(op_row(egsa_pkg::OP_READ,  10'd3,    6'd1,  32'h0,        0, 0,
                       egsa_pkg::ST_OK, 0));
        // zero rows: every row out of range
        add_row(reg_row(egsa_pkg::CFG_ROW_COUNT, 11'd0));
        add_row(op_row(egsa_pkg::OP_READ,  10'd0,    6'd0,  32'h0,        1, 32'h0,
                       egsa_pkg::ST_ROW_BAD, 0));
        // oversized rows, zero columns: every column out of range
        add_row(reg_row(egsa_pkg::CFG_ROW_COUNT, 11'd2047));
        add_row(reg_row(egsa_pkg::CFG_VECTOR_WIDTH, 11'd0));
        add_row(op_row(egsa_pkg::OP_ACCUM, 10'd1023, 6'd0,  32'h1,        1, 32'h0,
                       egsa_pkg::ST_COL_BAD, 0));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg)
                write_reg(dir_rows[k].cfg_index, dir_rows[k].cfg_data);
            else
                drive_item(dir_rows[k].item, dir_rows[k].fixed, dir_rows[k].want);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin rows_cfg = 11'd1024; cols_cfg = 11'd64;  end
                1: begin rows_cfg = 11'd2047; cols_cfg = 11'd127; end
                2: begin rows_cfg = 11'd0;    cols_cfg = 11'd64;  end
                3: begin rows_cfg = 11'd1024; cols_cfg = 11'd0;   end
                4: begin rows_cfg = 11'd1;    cols_cfg = 11'd1;   end
                5: begin rows_cfg = 11'd1025; cols_cfg = 11'd65;  end
                // bits above the 7-bit width register drop off
                6: begin rows_cfg = 11'd500;  cols_cfg = 11'h783; end
                default: begin
                    rows_cfg = egsa_pkg::CFG_DATA_W'($urandom_range(1, 1024));
                    cols_cfg = egsa_pkg::CFG_DATA_W'($urandom_range(1, 64));
                end
            endcase
            write_reg(egsa_pkg::CFG_ROW_COUNT, rows_cfg);
            write_reg(egsa_pkg::CFG_VECTOR_WIDTH, cols_cfg);
            lim_rows = (row_count_q > egsa_pkg::MAX_ROWS_DEF) ?
                       egsa_pkg::MAX_ROWS_DEF : int'(row_count_q);
            lim_cols = (vector_width_q > egsa_pkg::MAX_WIDTH_DEF) ?
                       egsa_pkg::MAX_WIDTH_DEF : int'(vector_width_q);

            // concentrate traffic on a few entries so sums build up and saturate
            for (k = 0; k < HOT_ENTRIES; k++) begin
                hot_row[k] = egsa_pkg::ROW_W'((lim_rows > 0) ?
                                              $urandom_range(0, lim_rows - 1) : $urandom);
                hot_col[k] = egsa_pkg::COL_W'((lim_cols > 0) ?
                                              $urandom_range(0, lim_cols - 1) : $urandom);
            end

            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                it   = ITEM_W'({$urandom, $urandom});
                pick = $urandom_range(0, 99);
                if (pick < 2 && clears_left > 0) begin
                    it.operation = egsa_pkg::OP_CLEAR;
                    clears_left--;
                end else if (pick < 4) begin
                    it.operation = OP_UNUSED;
                end else if (pick < 78) begin
                    hidx = $urandom_range(0, HOT_ENTRIES - 1);
                    it.row_index    = hot_row[hidx];
                    it.column_index = hot_col[hidx];
                    it.operation    = (pick < 55) ? egsa_pkg::OP_ACCUM : egsa_pkg::OP_READ;
                    case ($urandom_range(0, 3))
                        0: it.grad_value = $urandom;
                        1: it.grad_value = 32'h7FFF0000 | $urandom_range(0, 16'hFFFF);
                        2: it.grad_value = 32'h80000000 | $urandom_range(0, 16'hFFFF);
                        default: it.grad_value = $urandom_range(0, 32'h3FFFF) - 32'h20000;
                    endcase
                end else begin
                    it.operation = $urandom_range(0, 1) ? egsa_pkg::OP_READ :
                                                          egsa_pkg::OP_ACCUM;
                end
                drive_item(it, 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_sums.size() != 0) bad_results++;
        if (bad_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
